// ----- rtl/hjc_pkg.sv -----
// hjc_pkg: types, constants and jamo tables for the hangul jamo composer
// used by hangul_jamo_composer_unit; no dependencies
`default_nettype none

package hjc_pkg;

   localparam int CODE_W = 21;
   localparam int SLOT_W = 6;

   localparam logic OP_KEY       = 1'b0;
   localparam logic OP_BACKSPACE = 1'b1;

   localparam logic [CODE_W-1:0] JAMO_BASE  = 21'h003130;
   localparam logic [CODE_W-1:0] JAUM_FIRST = 21'h003131;
   localparam logic [CODE_W-1:0] JAUM_LAST  = 21'h00314E;
   localparam logic [CODE_W-1:0] MOUM_FIRST = 21'h00314F;
   localparam logic [CODE_W-1:0] MOUM_LAST  = 21'h003163;

   // slot offsets from the jamo base
   localparam logic [SLOT_W-1:0] SLOT_EMPTY = 6'h00;
   localparam logic [SLOT_W-1:0] VOWEL_LO   = 6'h1F;
   localparam logic [SLOT_W-1:0] VOWEL_HI   = 6'h33;

   localparam logic [15:0] SYL_FIRST   = 16'hAC00;
   localparam logic [15:0] LEAD_STRIDE = 16'd588;
   localparam logic [15:0] VOWEL_STRIDE = 16'd28;

   typedef struct packed {
      logic              opcode;
      logic [CODE_W-1:0] key_code;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] committed_syllable;
      logic [CODE_W-1:0] passed_char;
      logic [CODE_W-1:0] preedit_glyph;
      logic              done_flag;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] first;
      logic [SLOT_W-1:0] second;
   } pair_type;

   // bit 5 set when the jamo is a valid initial, low bits its index
   function automatic logic [5:0] lead_lookup(input logic [SLOT_W-1:0] c);
      logic [5:0] r;
      case (c)
         6'h01: r = {1'b1, 5'd0};
         6'h02: r = {1'b1, 5'd1};
         6'h04: r = {1'b1, 5'd2};
         6'h07: r = {1'b1, 5'd3};
         6'h08: r = {1'b1, 5'd4};
         6'h09: r = {1'b1, 5'd5};
         6'h11: r = {1'b1, 5'd6};
         6'h12: r = {1'b1, 5'd7};
         6'h13: r = {1'b1, 5'd8};
         6'h15: r = {1'b1, 5'd9};
         6'h16: r = {1'b1, 5'd10};
         6'h17: r = {1'b1, 5'd11};
         6'h18: r = {1'b1, 5'd12};
         6'h19: r = {1'b1, 5'd13};
         6'h1A: r = {1'b1, 5'd14};
         6'h1B: r = {1'b1, 5'd15};
         6'h1C: r = {1'b1, 5'd16};
         6'h1D: r = {1'b1, 5'd17};
         6'h1E: r = {1'b1, 5'd18};
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // final index 1..27, 0 for no final
   function automatic logic [4:0] tail_index(input logic [SLOT_W-1:0] c);
      logic [4:0] r;
      case (c)
         6'h01: r = 5'd1;
         6'h02: r = 5'd2;
         6'h03: r = 5'd3;
         6'h04: r = 5'd4;
         6'h05: r = 5'd5;
         6'h06: r = 5'd6;
         6'h07: r = 5'd7;
         6'h09: r = 5'd8;
         6'h0A: r = 5'd9;
         6'h0B: r = 5'd10;
         6'h0C: r = 5'd11;
         6'h0D: r = 5'd12;
         6'h0E: r = 5'd13;
         6'h0F: r = 5'd14;
         6'h10: r = 5'd15;
         6'h11: r = 5'd16;
         6'h12: r = 5'd17;
         6'h14: r = 5'd18;
         6'h15: r = 5'd19;
         6'h16: r = 5'd20;
         6'h17: r = 5'd21;
         6'h18: r = 5'd22;
         6'h1A: r = 5'd23;
         6'h1B: r = 5'd24;
         6'h1C: r = 5'd25;
         6'h1D: r = 5'd26;
         6'h1E: r = 5'd27;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] vowel_join(input logic [SLOT_W-1:0] a,
                                                    input logic [SLOT_W-1:0] b);
      logic [SLOT_W-1:0] r;
      case ({a, b})
         {6'h27, 6'h1F}: r = 6'h28;
         {6'h27, 6'h20}: r = 6'h29;
         {6'h27, 6'h33}: r = 6'h2A;
         {6'h2C, 6'h23}: r = 6'h2D;
         {6'h2C, 6'h24}: r = 6'h2E;
         {6'h2C, 6'h33}: r = 6'h2F;
         {6'h31, 6'h33}: r = 6'h32;
         default: r = SLOT_EMPTY;
      endcase
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] tail_join(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
      logic [SLOT_W-1:0] r;
      case ({a, b})
         {6'h01, 6'h15}: r = 6'h03;
         {6'h04, 6'h18}: r = 6'h05;
         {6'h04, 6'h1E}: r = 6'h06;
         {6'h09, 6'h01}: r = 6'h0A;
         {6'h09, 6'h11}: r = 6'h0B;
         {6'h09, 6'h12}: r = 6'h0C;
         {6'h09, 6'h15}: r = 6'h0D;
         {6'h09, 6'h1C}: r = 6'h0E;
         {6'h09, 6'h1D}: r = 6'h0F;
         {6'h09, 6'h1E}: r = 6'h10;
         {6'h12, 6'h15}: r = 6'h14;
         default: r = SLOT_EMPTY;
      endcase
      return r;
   endfunction

   function automatic pair_type vowel_split(input logic [SLOT_W-1:0] c);
      pair_type r;
      case (c)
         6'h28: r = '{first: 6'h27, second: 6'h1F};
         6'h29: r = '{first: 6'h27, second: 6'h20};
         6'h2A: r = '{first: 6'h27, second: 6'h33};
         6'h2D: r = '{first: 6'h2C, second: 6'h23};
         6'h2E: r = '{first: 6'h2C, second: 6'h24};
         6'h2F: r = '{first: 6'h2C, second: 6'h33};
         6'h32: r = '{first: 6'h31, second: 6'h33};
         default: r = '{first: c, second: SLOT_EMPTY};
      endcase
      return r;
   endfunction

   function automatic pair_type tail_split(input logic [SLOT_W-1:0] c);
      pair_type r;
      case (c)
         6'h03: r = '{first: 6'h01, second: 6'h15};
         6'h05: r = '{first: 6'h04, second: 6'h18};
         6'h06: r = '{first: 6'h04, second: 6'h1E};
         6'h0A: r = '{first: 6'h09, second: 6'h01};
         6'h0B: r = '{first: 6'h09, second: 6'h11};
         6'h0C: r = '{first: 6'h09, second: 6'h12};
         6'h0D: r = '{first: 6'h09, second: 6'h15};
         6'h0E: r = '{first: 6'h09, second: 6'h1C};
         6'h0F: r = '{first: 6'h09, second: 6'h1D};
         6'h10: r = '{first: 6'h09, second: 6'h1E};
         6'h14: r = '{first: 6'h12, second: 6'h15};
         default: r = '{first: c, second: SLOT_EMPTY};
      endcase
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] slot_code(input logic [SLOT_W-1:0] s);
      return (s == SLOT_EMPTY) ? '0 : (JAMO_BASE + CODE_W'(s));
   endfunction

   // precomposed syllable when possible, else the first nonempty jamo
   function automatic logic [CODE_W-1:0] compose(input logic [SLOT_W-1:0] l,
                                                 input logic [SLOT_W-1:0] v,
                                                 input logic [SLOT_W-1:0] t);
      logic [5:0]        li;
      logic [15:0]       syl;
      logic [CODE_W-1:0] r;
      li  = lead_lookup(l);
      syl = SYL_FIRST + 16'(li[4:0]) * LEAD_STRIDE
            + 16'(v - VOWEL_LO) * VOWEL_STRIDE + 16'(tail_index(t));
      if (li[5] && v >= VOWEL_LO && v <= VOWEL_HI) begin
         r = CODE_W'(syl);
      end else if (l != SLOT_EMPTY) begin
         r = slot_code(l);
      end else if (v != SLOT_EMPTY) begin
         r = slot_code(v);
      end else begin
         r = slot_code(t);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hangul_jamo_composer_unit.sv -----
// hangul_jamo_composer_unit: two-set hangul preedit composer, top level
// depends on hjc_pkg (types, jamo tables, compose function)
//
// Takes one key or backspace transaction per clock while req_ready is high
// and returns exactly one result per transaction, registered at acceptance. The
// preedit slots (initial, vowel, final) update at the accepting edge, so the next
// transaction may follow in the very next cycle. Results pass through an
// output register backed by a one-entry skid register: req_ready drops only
// while both hold undelivered results, so a result waiting on rsp_ready does
// not stop the next transaction from being taken.
`default_nettype none

module hangul_jamo_composer_unit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire hjc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output hjc_pkg::rsp_type     rsp_data
);

   logic [hjc_pkg::SLOT_W-1:0] lead_ff, lead_in;
   logic [hjc_pkg::SLOT_W-1:0] vowel_ff, vowel_in;
   logic [hjc_pkg::SLOT_W-1:0] tail_ff, tail_in;

   logic             out_valid_ff, skid_valid_ff;
   hjc_pkg::rsp_type out_ff, skid_ff;
   hjc_pkg::rsp_type result;

   logic req_fire, rsp_fire;

   logic [hjc_pkg::CODE_W-1:0] ch;
   logic [hjc_pkg::SLOT_W-1:0] c;
   logic                       is_cons, is_vowel, is_other;
   logic [7:0]                 ch_low;
   logic [hjc_pkg::SLOT_W-1:0] cm_v, cm_t;
   logic                       commit;
   logic                       done;
   logic [hjc_pkg::SLOT_W-1:0] tj_t, tj_l, vj;
   hjc_pkg::pair_type          ts, vs;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign ch       = req_data.key_code;
   assign ch_low   = ch[7:0] - 8'h30;
   assign c        = ch_low[hjc_pkg::SLOT_W-1:0];
   assign is_cons  = ch >= hjc_pkg::JAUM_FIRST && ch <= hjc_pkg::JAUM_LAST;
   assign is_vowel = ch >= hjc_pkg::MOUM_FIRST && ch <= hjc_pkg::MOUM_LAST;
   assign is_other = ch != '0 && !is_cons && !is_vowel;

   assign tj_t = hjc_pkg::tail_join(tail_ff, c);
   assign tj_l = hjc_pkg::tail_join(lead_ff, c);
   assign vj   = hjc_pkg::vowel_join(vowel_ff, c);
   assign ts   = hjc_pkg::tail_split(tail_ff);
   assign vs   = hjc_pkg::vowel_split(vowel_ff);

   always_comb begin
      lead_in  = lead_ff;
      vowel_in = vowel_ff;
      tail_in  = tail_ff;
      commit   = 1'b0;
      done     = 1'b0;
      cm_v     = vowel_ff;
      cm_t     = tail_ff;
      if (req_data.opcode == hjc_pkg::OP_BACKSPACE) begin
         done = 1'b1;
         if (tail_ff != hjc_pkg::SLOT_EMPTY) begin
            tail_in = (ts.second != hjc_pkg::SLOT_EMPTY) ? ts.first : hjc_pkg::SLOT_EMPTY;
         end else if (vowel_ff != hjc_pkg::SLOT_EMPTY) begin
            vowel_in = (vs.second != hjc_pkg::SLOT_EMPTY) ? vs.first : hjc_pkg::SLOT_EMPTY;
         end else if (lead_ff != hjc_pkg::SLOT_EMPTY) begin
            lead_in = hjc_pkg::SLOT_EMPTY;
         end else begin
            done = 1'b0;
         end
      end else if (is_other) begin
         commit   = 1'b1;
         done     = 1'b1;
         lead_in  = hjc_pkg::SLOT_EMPTY;
         vowel_in = hjc_pkg::SLOT_EMPTY;
         tail_in  = hjc_pkg::SLOT_EMPTY;
      end else if (tail_ff != hjc_pkg::SLOT_EMPTY) begin
         if (is_cons) begin
            if (tj_t != hjc_pkg::SLOT_EMPTY) begin
               tail_in = tj_t;
            end else begin
               commit   = 1'b1;
               done     = 1'b1;
               vowel_in = hjc_pkg::SLOT_EMPTY;
               tail_in  = hjc_pkg::SLOT_EMPTY;
               lead_in  = c;
            end
         end else if (is_vowel) begin
            commit = 1'b1;
            done   = 1'b1;
            if (ts.second != hjc_pkg::SLOT_EMPTY) begin
               cm_t    = ts.first;
               lead_in = ts.second;
            end else begin
               cm_t    = hjc_pkg::SLOT_EMPTY;
               lead_in = ts.first;
            end
            vowel_in = c;
            tail_in  = hjc_pkg::SLOT_EMPTY;
         end
      end else if (vowel_ff != hjc_pkg::SLOT_EMPTY) begin
         cm_t = hjc_pkg::SLOT_EMPTY;
         if (is_cons) begin
            if (lead_ff != hjc_pkg::SLOT_EMPTY && hjc_pkg::tail_index(c) != 5'd0) begin
               tail_in = c;
            end else begin
               commit   = 1'b1;
               done     = 1'b1;
               vowel_in = hjc_pkg::SLOT_EMPTY;
               lead_in  = c;
            end
         end else if (is_vowel) begin
            if (vj != hjc_pkg::SLOT_EMPTY) begin
               vowel_in = vj;
            end else begin
               commit   = 1'b1;
               done     = 1'b1;
               lead_in  = hjc_pkg::SLOT_EMPTY;
               vowel_in = c;
            end
         end
      end else if (lead_ff != hjc_pkg::SLOT_EMPTY) begin
         cm_v = hjc_pkg::SLOT_EMPTY;
         cm_t = hjc_pkg::SLOT_EMPTY;
         if (is_cons) begin
            if (tj_l != hjc_pkg::SLOT_EMPTY) begin
               lead_in = hjc_pkg::SLOT_EMPTY;
               tail_in = tj_l;
            end else begin
               commit  = 1'b1;
               done    = 1'b1;
               lead_in = c;
            end
         end else if (is_vowel) begin
            vowel_in = c;
         end
      end else begin
         if (is_cons) begin
            lead_in = c;
         end else if (is_vowel) begin
            vowel_in = c;
         end
      end
   end

   always_comb begin
      result.committed_syllable = commit ? hjc_pkg::compose(lead_ff, cm_v, cm_t) : '0;
      result.passed_char        = (req_data.opcode == hjc_pkg::OP_KEY && is_other) ? ch : '0;
      result.preedit_glyph      = hjc_pkg::compose(lead_in, vowel_in, tail_in);
      result.done_flag          = done;
   end

   // preedit slots
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= hjc_pkg::SLOT_EMPTY;
         vowel_ff <= hjc_pkg::SLOT_EMPTY;
         tail_ff  <= hjc_pkg::SLOT_EMPTY;
      end else if (req_fire) begin
         lead_ff  <= lead_in;
         vowel_ff <= vowel_in;
         tail_ff  <= tail_in;
      end
   end

   // output register and skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (!out_valid_ff || rsp_fire) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end else if (rsp_fire && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

endmodule

`default_nettype wire
